/* rtl/drbt_pkg.sv */
// drbt_pkg: shared constants, codes and types of the dram bank row buffer timing block
// no dependencies; the design files but drbt_ram take names from here by scope, the testbench imports it
`default_nettype none

package drbt_pkg;

    // geometry
    localparam int BANK_COUNT = 16;
    localparam int ROW_BYTES  = 1024;
    localparam int ADDR_BITS  = 32;

    localparam int BANK_BITS  = $clog2(BANK_COUNT);
    localparam int ROW_SHIFT  = $clog2(ROW_BYTES);
    localparam int TAG_BITS   = 28;
    localparam int LSL_BITS   = 4;
    localparam int WIDE_BITS  = 64;

    // timing in cycles
    localparam int LAT_BITS         = 8;
    localparam logic [7:0] LAT_FIXED = 8'd100;
    localparam logic [7:0] LAT_ACT   = 8'd45;
    localparam logic [7:0] LAT_CAS   = 8'd45;
    localparam logic [7:0] LAT_PRE   = 8'd45;
    localparam logic [7:0] LAT_BUS   = 8'd10;

    // statistics widths
    localparam int CNT_BITS = 32;
    localparam int SUM_BITS = 40;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 4;
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FIXED_MODE = 2'd0,
        CFG_OPEN_PAGE  = 2'd1,
        CFG_LINE_LOG2  = 2'd2
    } cfg_idx_t;

    // row buffer outcome codes
    typedef enum logic [1:0] {
        OUT_FIXED    = 2'd0,
        OUT_EMPTY    = 2'd1,
        OUT_HIT      = 2'd2,
        OUT_CONFLICT = 2'd3
    } outcome_t;

    // control state
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOOK = 2'b10
    } state_t;

    // running statistics
    typedef struct packed {
        logic [CNT_BITS-1:0] read_count;
        logic [SUM_BITS-1:0] read_delay_total;
        logic [CNT_BITS-1:0] write_count;
        logic [SUM_BITS-1:0] write_delay_total;
    } stats_t;

    // one finished access, handed to the statistics unit
    typedef struct packed {
        logic                commit;
        logic                is_write;
        logic [LAT_BITS-1:0] latency;
    } stat_upd_t;

endpackage

`default_nettype wire

/* rtl/drbt_if.sv */
// drbt channel interfaces: request, response and configuration write
// depends on drbt_pkg for field widths
`default_nettype none

// request channel
interface drbt_req_if;
    logic                           valid;
    logic                           ready;
    logic                           req_type;
    logic [drbt_pkg::ADDR_BITS-1:0] line_address;

    modport source (output valid, output req_type, output line_address, input ready);
    modport sink   (input valid, input req_type, input line_address, output ready);
endinterface

// response channel
interface drbt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [drbt_pkg::LAT_BITS-1:0]  latency;
    logic [1:0]                     outcome;
    logic [drbt_pkg::CNT_BITS-1:0]  read_count;
    logic [drbt_pkg::SUM_BITS-1:0]  read_delay_total;
    logic [drbt_pkg::CNT_BITS-1:0]  write_count;
    logic [drbt_pkg::SUM_BITS-1:0]  write_delay_total;

    modport source (output valid, output latency, output outcome, output read_count,
                    output read_delay_total, output write_count,
                    output write_delay_total, input ready);
    modport sink   (input valid, input latency, input outcome, input read_count,
                    input read_delay_total, input write_count,
                    input write_delay_total, output ready);
endinterface

// configuration write channel
interface drbt_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [drbt_pkg::CFG_IDX_BITS-1:0]  index;
    logic [drbt_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/dram_bank_row_buffer_timing.sv */
// channel  dir  handshake          payload
// req      in   valid & ready      req_type, line_address
// rsp      out  valid & ready      latency, outcome, read/write counts and delay totals
// cfg      in   valid & ready      index, data (ready always high)
//
// per item: accept and tag ram read, then compare, bank update and commit;
// the tag ram read is registered; the next item is taken only after the commit,
// while a finished result may still wait in the response register
// a result that is not taken stalls the lookup cycle, never the waiting result
// reset clears bank open bits and statistics and sets configuration defaults; tag ram needs no reset
// depends on drbt_pkg, drbt_if, drbt_ram and drbt_stats
`default_nettype none

module dram_bank_row_buffer_timing (
    input  wire logic clk,
    input  wire logic rst_n,
    drbt_req_if.sink   req,
    drbt_rsp_if.source rsp,
    drbt_cfg_if.sink   cfg
);

    // configuration registers
    logic                               fixed_mode_reg;
    logic                               keep_row_reg;
    logic [drbt_pkg::LSL_BITS-1:0]      line_log2_reg;

    // control and lookup state
    drbt_pkg::state_t                   state_reg, state_next;
    logic [drbt_pkg::BANK_COUNT-1:0]    open_reg;
    logic [drbt_pkg::BANK_BITS-1:0]     bank_reg;
    logic [drbt_pkg::TAG_BITS-1:0]      tag_reg;
    logic                               is_write_reg;

    // response register
    logic                               out_valid_reg;
    logic [drbt_pkg::LAT_BITS-1:0]      latency_reg;
    drbt_pkg::outcome_t                 outcome_reg;
    drbt_pkg::stats_t                   stats_reg;

    logic                               accept;
    logic                               commit;
    logic [drbt_pkg::WIDE_BITS-1:0]     byte_addr;
    logic [drbt_pkg::WIDE_BITS-1:0]     row_num;
    logic [drbt_pkg::TAG_BITS-1:0]      ram_rdata;
    logic                               ram_we;
    drbt_pkg::outcome_t                 outcome;
    logic [drbt_pkg::LAT_BITS-1:0]      latency;
    drbt_pkg::stat_upd_t                upd;
    drbt_pkg::stats_t                   stats_next;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_mode_reg <= 1'b0;
            keep_row_reg   <= 1'b1;
            line_log2_reg  <= drbt_pkg::LSL_BITS'(6);
        end
        else if (cfg.valid)
        begin
            case (drbt_pkg::cfg_idx_t'(cfg.index))
                drbt_pkg::CFG_FIXED_MODE: fixed_mode_reg <= cfg.data[0];
                drbt_pkg::CFG_OPEN_PAGE:  keep_row_reg   <= cfg.data[0];
                drbt_pkg::CFG_LINE_LOG2:  line_log2_reg  <= cfg.data[drbt_pkg::LSL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // address mapping: line -> byte -> row -> bank and tag
    assign byte_addr = drbt_pkg::WIDE_BITS'(req.line_address) << line_log2_reg;
    assign row_num   = byte_addr >> drbt_pkg::ROW_SHIFT;

    assign req.ready = (state_reg == drbt_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign commit    = (state_reg == drbt_pkg::ST_LOOK) && (!out_valid_reg || rsp.ready);

    // open row tag store
    drbt_ram #(
        .WIDTH (drbt_pkg::TAG_BITS),
        .DEPTH (drbt_pkg::BANK_COUNT)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (bank_reg),
        .wdata (tag_reg),
        .re    (accept),
        .raddr (row_num[drbt_pkg::BANK_BITS-1:0]),
        .rdata (ram_rdata)
    );

    // classify the access and price it
    always_comb
    begin
        outcome = drbt_pkg::OUT_FIXED;
        latency = drbt_pkg::LAT_FIXED;
        ram_we  = 1'b0;
        if (!fixed_mode_reg)
        begin
            if (!open_reg[bank_reg])
            begin
                outcome = drbt_pkg::OUT_EMPTY;
                latency = drbt_pkg::LAT_ACT + drbt_pkg::LAT_CAS + drbt_pkg::LAT_BUS;
                ram_we  = commit;
            end
            else if (ram_rdata == tag_reg)
            begin
                outcome = drbt_pkg::OUT_HIT;
                latency = keep_row_reg ? drbt_pkg::LAT_CAS + drbt_pkg::LAT_BUS
                        : drbt_pkg::LAT_ACT + drbt_pkg::LAT_CAS + drbt_pkg::LAT_BUS;
            end
            else
            begin
                outcome = drbt_pkg::OUT_CONFLICT;
                latency = keep_row_reg
                        ? drbt_pkg::LAT_PRE + drbt_pkg::LAT_ACT + drbt_pkg::LAT_CAS
                          + drbt_pkg::LAT_BUS
                        : drbt_pkg::LAT_ACT + drbt_pkg::LAT_CAS + drbt_pkg::LAT_BUS;
                ram_we  = commit;
            end
        end
    end

    // statistics
    assign upd.commit   = commit;
    assign upd.is_write = is_write_reg;
    assign upd.latency  = latency;

    drbt_stats u_stats (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (upd),
        .stats_next (stats_next)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            drbt_pkg::ST_IDLE: if (accept) state_next = drbt_pkg::ST_LOOK;
            drbt_pkg::ST_LOOK: if (commit) state_next = drbt_pkg::ST_IDLE;
            default:           state_next = drbt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= drbt_pkg::ST_IDLE;
            open_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit && !fixed_mode_reg)
            begin
                open_reg[bank_reg] <= 1'b1;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // lookup and response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bank_reg     <= row_num[drbt_pkg::BANK_BITS-1:0];
            tag_reg      <= row_num[drbt_pkg::BANK_BITS +: drbt_pkg::TAG_BITS];
            is_write_reg <= req.req_type;
        end
        if (commit)
        begin
            latency_reg <= latency;
            outcome_reg <= outcome;
            stats_reg   <= stats_next;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.latency           = latency_reg;
    assign rsp.outcome           = outcome_reg;
    assign rsp.read_count        = stats_reg.read_count;
    assign rsp.read_delay_total  = stats_reg.read_delay_total;
    assign rsp.write_count       = stats_reg.write_count;
    assign rsp.write_delay_total = stats_reg.write_delay_total;

    // an accepted item always goes to lookup next
    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == drbt_pkg::ST_LOOK)
        else $error("accepted item did not enter lookup");

    // a pending result that is not taken holds the lookup
    a_stall_look: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == drbt_pkg::ST_LOOK && out_valid_reg && !rsp.ready)
        |=> state_reg == drbt_pkg::ST_LOOK)
        else $error("lookup committed over an untaken result");

    // tag writes only happen at commit
    a_we_commit: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> commit && !fixed_mode_reg)
        else $error("tag ram write outside commit");

    // a committed timed access leaves its bank open
    a_bank_open: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !fixed_mode_reg) |=> open_reg[$past(bank_reg)])
        else $error("bank not open after access");

    // a hit only on an open bank and without a tag write
    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && outcome == drbt_pkg::OUT_HIT) |-> open_reg[bank_reg] && !ram_we)
        else $error("row hit on closed bank or with tag write");

endmodule

`default_nettype wire

/* rtl/drbt_ram.sv */
// drbt_ram: generic single write port, single read port ram with registered read
// no package dependencies
`default_nettype none

module drbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/drbt_stats.sv */
// drbt_stats: saturating read/write access counters and delay totals
// depends on drbt_pkg for widths and the update/statistics structs
`default_nettype none

module drbt_stats (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire drbt_pkg::stat_upd_t upd,
    output drbt_pkg::stats_t         stats_next
);

    drbt_pkg::stats_t          stats_reg;
    logic [drbt_pkg::SUM_BITS:0] add_sum;
    logic [drbt_pkg::SUM_BITS-1:0] sel_sum;
    logic [drbt_pkg::CNT_BITS-1:0] sel_cnt;
    logic [drbt_pkg::CNT_BITS-1:0] cnt_inc;
    logic [drbt_pkg::SUM_BITS-1:0] sum_inc;

    // pick the side this item counts on
    assign sel_cnt = upd.is_write ? stats_reg.write_count : stats_reg.read_count;
    assign sel_sum = upd.is_write ? stats_reg.write_delay_total : stats_reg.read_delay_total;

    // saturating increments
    assign add_sum = {1'b0, sel_sum} + (drbt_pkg::SUM_BITS + 1)'(upd.latency);
    assign cnt_inc = (&sel_cnt) ? sel_cnt : sel_cnt + 1'b1;
    assign sum_inc = add_sum[drbt_pkg::SUM_BITS] ? {drbt_pkg::SUM_BITS{1'b1}}
                                                 : add_sum[drbt_pkg::SUM_BITS-1:0];

    // next statistics, also the values reported with this item
    always_comb
    begin
        stats_next = stats_reg;
        if (upd.commit)
        begin
            if (upd.is_write)
            begin
                stats_next.write_count       = cnt_inc;
                stats_next.write_delay_total = sum_inc;
            end
            else
            begin
                stats_next.read_count       = cnt_inc;
                stats_next.read_delay_total = sum_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_reg <= '0;
        end
        else
        begin
            stats_reg <= stats_next;
        end
    end

endmodule

`default_nettype wire

/* tb/drbt_access_check.sv */
`timescale 1ns / 1ps
// access checker for the dram bank row buffer timing block: watches the three
// channels, predicts each result and compares it; depends on drbt_pkg and drbt_if
module drbt_access_check
    import drbt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    drbt_req_if  req,
    drbt_rsp_if  rsp,
    drbt_cfg_if  cfg,
    output int   mismatch_count,
    output int   pending,
    output int   checked
);

    // one predicted response item
    typedef struct packed {
        logic [LAT_BITS-1:0] latency;
        outcome_t            outcome;
        stats_t              stats;
    } access_timing_t;

    // local copy of the configuration
    logic                fixed_mode;
    logic                keep_row;
    logic [LSL_BITS-1:0] line_log2;

    // local copy of the bank state and statistics
    logic                bank_open [BANK_COUNT];
    logic [TAG_BITS-1:0] bank_tag  [BANK_COUNT];
    stats_t              totals;

    access_timing_t awaited_timing [$];

    function automatic logic [CNT_BITS-1:0] count_up(input logic [CNT_BITS-1:0] n);
        count_up = (n == '1) ? n : n + 1'b1;
    endfunction

    function automatic logic [SUM_BITS-1:0] sum_up(input logic [SUM_BITS-1:0] s,
                                                   input logic [LAT_BITS-1:0] lat);
        logic [SUM_BITS:0] wide;
        wide = {1'b0, s} + lat;
        sum_up = wide[SUM_BITS] ? '1 : wide[SUM_BITS-1:0];
    endfunction

    // row buffer lookup, bank update and statistics for one access
    function automatic access_timing_t timing_of_access(input logic is_write,
                                                        input logic [ADDR_BITS-1:0] addr);
        access_timing_t      r;
        logic [63:0]         row;
        logic [BANK_BITS-1:0] bank;
        logic [TAG_BITS-1:0] tag;
        logic [LAT_BITS-1:0] lat;
        outcome_t            oc;
        if (fixed_mode)
        begin
            lat = LAT_FIXED;
            oc  = OUT_FIXED;
        end
        else
        begin
            row  = ({32'd0, addr} << line_log2) >> ROW_SHIFT;
            bank = row[BANK_BITS-1:0];
            tag  = row[BANK_BITS +: TAG_BITS];
            if (!bank_open[bank])
            begin
                oc  = OUT_EMPTY;
                lat = LAT_ACT + LAT_CAS;
                bank_open[bank] = 1'b1;
                bank_tag[bank]  = tag;
            end
            else if (bank_tag[bank] == tag)
            begin
                oc  = OUT_HIT;
                lat = keep_row ? LAT_CAS : LAT_ACT + LAT_CAS;
            end
            else
            begin
                oc  = OUT_CONFLICT;
                lat = keep_row ? LAT_PRE + LAT_ACT + LAT_CAS : LAT_ACT + LAT_CAS;
                bank_tag[bank] = tag;
            end
            lat = lat + LAT_BUS;
        end
        if (is_write)
        begin
            totals.write_count       = count_up(totals.write_count);
            totals.write_delay_total = sum_up(totals.write_delay_total, lat);
        end
        else
        begin
            totals.read_count       = count_up(totals.read_count);
            totals.read_delay_total = sum_up(totals.read_delay_total, lat);
        end
        r.latency = lat;
        r.outcome = oc;
        r.stats   = totals;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        access_timing_t want;
        logic           bad;
        if (!rst_n)
        begin
            fixed_mode = 1'b0;
            keep_row   = 1'b1;
            line_log2  = 4'd6;
            totals     = '0;
            for (int b = 0; b < BANK_COUNT; b++)
            begin
                bank_open[b] = 1'b0;
                bank_tag[b]  = '0;
            end
            awaited_timing.delete();
            mismatch_count = 0;
            pending        = 0;
            checked        = 0;
        end
        else
        begin
            // response item: compare with the oldest prediction
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_timing.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] response item with nothing outstanding", $realtime);
                end
                else
                begin
                    want = awaited_timing.pop_front();
                    checked++;
                    bad = 1'b0;
                    if (rsp.latency !== want.latency)                       bad = 1'b1;
                    if (rsp.outcome !== want.outcome)                       bad = 1'b1;
                    if (rsp.read_count !== want.stats.read_count)           bad = 1'b1;
                    if (rsp.read_delay_total !== want.stats.read_delay_total) bad = 1'b1;
                    if (rsp.write_count !== want.stats.write_count)         bad = 1'b1;
                    if (rsp.write_delay_total !== want.stats.write_delay_total)
                        bad = 1'b1;
                    if (bad)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("[%0t] result %0d mismatch (expected / actual):",
                                     $realtime, checked);
                            $display("    latency %0d / %0d  outcome %0d / %0d",
                                     want.latency, rsp.latency, want.outcome, rsp.outcome);
                            $display("    reads %0d / %0d  read cycles %0d / %0d",
                                     want.stats.read_count, rsp.read_count,
                                     want.stats.read_delay_total, rsp.read_delay_total);
                            $display("    writes %0d / %0d  write cycles %0d / %0d",
                                     want.stats.write_count, rsp.write_count,
                                     want.stats.write_delay_total, rsp.write_delay_total);
                        end
                    end
                end
            end
            // register write, unknown indexes are dropped
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_FIXED_MODE: fixed_mode = cfg.data[0];
                    CFG_OPEN_PAGE:  keep_row   = cfg.data[0];
                    CFG_LINE_LOG2:  line_log2  = cfg.data[LSL_BITS-1:0];
                    default: ;
                endcase
            end
            // request item: predict its result
            if (req.valid && req.ready)
                awaited_timing.push_back(timing_of_access(req.req_type, req.line_address));
            pending = awaited_timing.size();
        end
    end

endmodule

/* tb/dram_bank_row_buffer_timing_tb.sv */
`timescale 1ns / 1ps
// top of the dram bank row buffer timing testbench: clock, reset, access stimulus
// under several register settings, response stalls and verdict; uses drbt_access_check
module dram_bank_row_buffer_timing_tb;
    import drbt_pkg::*;

    localparam int CLK_HIGH       = 6;
    localparam int CLK_LOW        = 6;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int PHASES         = 10;
    localparam int ITEMS_PER_PHASE = 62;
    localparam int TAIL_CYCLES    = 10;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam logic READ  = 1'b0;
    localparam logic WRITE = 1'b1;

    // response stall patterns
    typedef enum int { RX_ALWAYS, RX_COIN, RX_EVERY4, RX_RARE_STALL } rx_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int mismatch_count;
    int pending;
    int checked;
    int cycle_count   = 0;
    int items_sent    = 0;
    int settings_used = 0;
    int burst_left    = 0;

    logic [LSL_BITS-1:0] cur_line_log2 = 4'd6;
    logic [31:0]         tag_pool [4];
    logic [63:0]         last_row = '0;

    drbt_req_if req_ch ();
    drbt_rsp_if rsp_ch ();
    drbt_cfg_if cfg_ch ();

    dram_bank_row_buffer_timing u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    drbt_access_check u_access_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .cfg            (cfg_ch),
        .mismatch_count (mismatch_count),
        .pending        (pending),
        .checked        (checked)
    );

    // clock
    always
    begin
        #CLK_LOW clk = 1'b1;
        #CLK_HIGH clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // response side stalls, in a pattern that is picked anew at random
    initial
    begin
        rx_mode_t mode;
        int       left;
        int       tick;
        rsp_ch.ready = 1'b0;
        mode = RX_ALWAYS;
        left = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = rx_mode_t'($urandom_range(0, 3));
                left = $urandom_range(20, 80);
            end
            left--;
            tick++;
            case (mode)
                RX_ALWAYS:     rsp_ch.ready = 1'b1;
                RX_COIN:       rsp_ch.ready = 1'($urandom_range(0, 1));
                RX_EVERY4:     rsp_ch.ready = (tick % 4 == 0);
                default:       rsp_ch.ready = ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // one access item; valid stays high inside a burst, gaps fall between bursts
    task automatic send_access(input logic is_write, input logic [ADDR_BITS-1:0] addr);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req_ch.valid        = 1'b1;
        req_ch.req_type     = is_write;
        req_ch.line_address = addr;
        // ready is settled mid-cycle, so the item goes at the next rising edge
        while (!req_ch.ready) @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    // stop sending and wait until every result is back
    task automatic drain();
        @(negedge clk);
        req_ch.valid = 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        if (idx == CFG_LINE_LOG2)
            cur_line_log2 = value;
    endtask

    // all three registers; upper data bits are junk for the one-bit ones
    task automatic apply_setting(input logic fixed, input logic open_pg,
                                 input logic [LSL_BITS-1:0] lsl);
        drain();
        write_reg(CFG_FIXED_MODE, {3'($urandom()), fixed});
        write_reg(CFG_OPEN_PAGE, {3'($urandom()), open_pg});
        write_reg(CFG_LINE_LOG2, lsl);
        settings_used++;
    endtask

    // address with locality: repeat a row, reuse a small tag set, or anything
    function automatic logic [ADDR_BITS-1:0] pick_address(input logic [LSL_BITS-1:0] shift);
        logic [63:0] row;
        logic [63:0] line;
        int          choice;
        choice = $urandom_range(0, 9);
        if (choice < 2)
            return $urandom();
        if (choice < 5)
            row = last_row;
        else
            row = {28'd0, tag_pool[$urandom_range(0, 3)], 4'($urandom_range(0, 15))};
        last_row = row;
        if (shift <= ROW_SHIFT)
            line = (row << (ROW_SHIFT - shift))
                 | (64'($urandom()) & ((64'd1 << (ROW_SHIFT - shift)) - 1));
        else
            line = row >> (shift - ROW_SHIFT);
        return line[ADDR_BITS-1:0];
    endfunction

    initial
    begin
        logic fixed;
        logic open_pg;
        logic [LSL_BITS-1:0] lsl;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = READ;
        req_ch.line_address = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_FIXED_MODE;
        cfg_ch.data         = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: open page, 64-byte lines
        send_access(READ, 32'h0000_0000);     // empty bank
        send_access(READ, 32'h0000_0000);     // row hit
        send_access(WRITE, 32'h0000_000F);    // hit, last line of the row
        send_access(WRITE, 32'h0000_0100);    // conflict in bank 0
        send_access(READ, 32'hFFFF_FFFF);     // empty bank 15
        send_access(WRITE, 32'hFFFF_FFFF);    // hit
        send_access(READ, 32'h8000_0000);     // conflict, high tag
        // closed page, value carries junk above the kept bit
        drain();
        write_reg(CFG_OPEN_PAGE, 4'b1110);
        send_access(READ, 32'h0000_0000);
        send_access(READ, 32'h0000_0000);
        send_access(WRITE, 32'h0000_0010);
        // line wider than a row, tags that alias above bit 27
        drain();
        write_reg(CFG_OPEN_PAGE, 4'b0001);
        write_reg(CFG_LINE_LOG2, 4'd15);
        send_access(READ, 32'h0000_0000);
        send_access(READ, 32'h8000_0000);
        send_access(WRITE, 32'h0000_0001);
        send_access(WRITE, 32'h7FFF_FFFF);
        // one-byte lines
        drain();
        write_reg(CFG_LINE_LOG2, 4'd0);
        send_access(READ, 32'hFFFF_FFFF);
        send_access(WRITE, 32'h0000_03FF);
        // one line per row
        drain();
        write_reg(CFG_LINE_LOG2, 4'd10);
        send_access(READ, 32'h5555_5555);
        send_access(WRITE, 32'hAAAA_AAAA);
        // fixed latency, then an index outside the register map
        drain();
        write_reg(CFG_FIXED_MODE, 4'b1111);
        send_access(READ, 32'h0000_0000);
        send_access(WRITE, 32'hFFFF_FFFF);
        drain();
        write_reg(CFG_UNUSED_IDX, 4'hF);
        send_access(READ, 32'h0000_0000);
        drain();
        write_reg(CFG_FIXED_MODE, 4'b0000);
        write_reg(CFG_LINE_LOG2, 4'd11);
        send_access(READ, 32'h0000_0000);
        send_access(WRITE, 32'h0000_0001);

        // random phases, extremes first
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin fixed = 1'b0; open_pg = 1'b1; lsl = 4'd0;  end
                1:       begin fixed = 1'b0; open_pg = 1'b0; lsl = 4'd10; end
                2:       begin fixed = 1'b0; open_pg = 1'b1; lsl = 4'd15; end
                3:       begin fixed = 1'b1; open_pg = 1'b1; lsl = 4'd6;  end
                default:
                begin
                    fixed   = ($urandom_range(0, 4) == 0);
                    open_pg = 1'($urandom_range(0, 1));
                    lsl     = LSL_BITS'($urandom_range(0, 15));
                end
            endcase
            tag_pool[0] = 32'd0;
            tag_pool[1] = $urandom_range(1, 7);
            tag_pool[2] = $urandom();
            tag_pool[3] = $urandom() | 32'hF000_0000;
            apply_setting(fixed, open_pg, lsl);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_access(1'($urandom_range(0, 1)), pick_address(cur_line_log2));
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("sent %0d accesses under %0d register settings plus directed cases",
                 items_sent, settings_used);
        $display("checked %0d results, %0d mismatches", checked, mismatch_count);
        if (mismatch_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
rtl/drbt_pkg.sv
rtl/drbt_if.sv
rtl/drbt_ram.sv
rtl/drbt_stats.sv
rtl/dram_bank_row_buffer_timing.sv
tb/drbt_access_check.sv
tb/dram_bank_row_buffer_timing_tb.sv
